// File: rtl/tgd_pkg.sv
// Shared types, constants and helper functions of the texture gradient descriptor.
// No dependencies; every other file of the block imports this package.
package tgd_pkg;

  localparam int CHAN_W   = 8;
  localparam int SUM_W    = 10;
  localparam int NUM_DIRS = 4;
  localparam int CFG_W    = 12;
  localparam int COORD_W  = 11;
  localparam int VAL_W    = 8;

  // Neighbor lanes
  localparam int DIR_LEFT  = 0;
  localparam int DIR_RIGHT = 1;
  localparam int DIR_UP    = 2;
  localparam int DIR_DOWN  = 3;

  localparam int MIN_DIM = 3;

  // floor(m / 3) = (m * 683) >> 11 for every m below 2047
  localparam int RECIP3      = 683;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W      = 20;

  localparam logic [VAL_W-1:0] VAL_MAX = 8'd255;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [1:0]        nch_t;

  localparam nch_t RESET_CHANNEL_COUNT = 2'd1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // Channel a sits in the low byte, as in the line stores
  typedef struct packed {
    chan_t c;
    chan_t b;
    chan_t a;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               emit;      // row above exists, item yields results
    logic               compute;   // interior pixel of the row above
    logic               last_row;
    logic               last_col;
  } item_meta_t;

  // Divide the largest sum by the channel count and clamp to the byte range
  function automatic logic [VAL_W-1:0] scale_value(sum_t m, nch_t nch);
    logic [PROD_W-1:0] prod;
    sum_t              q;
    prod = PROD_W'(m) * PROD_W'(RECIP3);
    case (nch)
      2'd3:    q = SUM_W'(prod >> RECIP_SHIFT);
      2'd2:    q = m >> 1;
      default: q = m;
    endcase
    return (q > SUM_W'(VAL_MAX)) ? VAL_MAX : q[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/tgd_if.sv
// Stream interfaces of the texture gradient descriptor: pixel items in, result items out.
// Depends on tgd_pkg for the field types.
interface tgd_pixel_if import tgd_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t chan_a;
  chan_t chan_b;
  chan_t chan_c;

  modport source (output valid, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface tgd_result_if import tgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   texture_value;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic               run_last;
  logic               frame_done;

  modport source (output valid, texture_value, out_column, out_row, run_last, frame_done,
                  input ready);
  modport sink   (input valid, texture_value, out_column, out_row, run_last, frame_done,
                  output ready);
endinterface

// File: rtl/tgd_line_store.sv
// One image line of pixels: one write port, one read port with registered read data.
// Depends on tgd_pkg for the pixel type.
module tgd_line_store import tgd_pkg::*; #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  pixel_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output pixel_t            rdata
);

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tgd_diff_lane.sv
// One neighbor lane: absolute differences summed over the active channels.
// Depends on tgd_pkg for pixel and sum types.
module tgd_diff_lane import tgd_pkg::*; (
  input  pixel_t center,
  input  pixel_t neighbor,
  input  nch_t   nch,
  output sum_t   sum
);

  chan_t da;
  chan_t db;
  chan_t dc;
  logic  en_b;
  logic  en_c;

  always_comb begin
    da   = (center.a > neighbor.a) ? center.a - neighbor.a : neighbor.a - center.a;
    db   = (center.b > neighbor.b) ? center.b - neighbor.b : neighbor.b - center.b;
    dc   = (center.c > neighbor.c) ? center.c - neighbor.c : neighbor.c - center.c;
    en_b = (nch == 2'd2) || (nch == 2'd3);
    en_c = (nch == 2'd3);
    sum  = SUM_W'(da) + (en_b ? SUM_W'(db) : '0) + (en_c ? SUM_W'(dc) : '0);
  end

endmodule

// File: rtl/tgd_merge.sv
// Merge of the neighbor lanes: largest of the four difference sums.
// Depends on tgd_pkg for the sum type and lane count.
module tgd_merge import tgd_pkg::*; (
  input  sum_t [NUM_DIRS-1:0] sums,
  output sum_t                max_sum
);

  sum_t max_lr;
  sum_t max_ud;

  always_comb begin
    max_lr  = (sums[DIR_RIGHT] > sums[DIR_LEFT]) ? sums[DIR_RIGHT] : sums[DIR_LEFT];
    max_ud  = (sums[DIR_DOWN] > sums[DIR_UP]) ? sums[DIR_DOWN] : sums[DIR_UP];
    max_sum = (max_ud > max_lr) ? max_ud : max_lr;
  end

endmodule

// File: rtl/texture_gradient_descriptor.sv
// Top level of the texture gradient descriptor.
// Depends on tgd_pkg, tgd_if, tgd_line_store, tgd_diff_lane and tgd_merge.

// Pixels enter in raster order, one item a cycle while ready is high, and each item of
// row y releases the result for the pixel above it at row y-1; items of row 0 release
// nothing, and items of the last row release a second result, always 0, for
// themselves, the last one flagged frame_done. The input side takes one item every
// clock cycle while the output keeps up; the single output register hands out one
// result a cycle while ready, so the last row, with two results per item, slows input. The
// item and its line-store reads are registered as it is taken, then come the four neighbor
// lanes, the lane merge, and the scale into the output register. Two line stores of
// MAX_WIDTH pixels each hold the two previous rows; the center pixel comes from the
// look-ahead read of the previous item, so each store sees one read and one write per
// item. The stores hold no defined data after reset and need no clearing. Configuration
// is written through cfg_en/cfg_index/cfg_data by the user while the block is idle; the
// block itself does not enforce this. Widths and heights are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT, and a channel count of zero acts as one.
module texture_gradient_descriptor import tgd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tgd_pixel_if.sink        pixel_in,
  tgd_result_if.source     result_out
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  // ---------------------------------------------------------------- configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  nch_t             channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RESET_FRAME_WIDTH;
      frame_height  <= RESET_FRAME_HEIGHT;
      channel_count <= RESET_CHANNEL_COUNT;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [WCMP_W-1:0] fw_ext;
  logic [WCMP_W-1:0] width_eff;
  logic [HCMP_W-1:0] fh_ext;
  logic [HCMP_W-1:0] height_eff;
  nch_t              nch_eff;

  // Clamp the frame size into the range the stores and counters can hold
  always_comb begin
    fw_ext = WCMP_W'(frame_width);
    fh_ext = HCMP_W'(frame_height);
    if (fw_ext < WCMP_W'(MIN_DIM)) begin
      width_eff = WCMP_W'(MIN_DIM);
    end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
      width_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
    if (fh_ext < HCMP_W'(MIN_DIM)) begin
      height_eff = HCMP_W'(MIN_DIM);
    end else if (fh_ext > HCMP_W'(MAX_HEIGHT)) begin
      height_eff = HCMP_W'(MAX_HEIGHT);
    end else begin
      height_eff = fh_ext;
    end
    nch_eff = (channel_count == 2'd0) ? 2'd1 : channel_count;
  end

  // ---------------------------------------------------------------- position counters
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic             last_col;
  logic             last_row;
  logic             accept;
  item_meta_t       in_meta;
  pixel_t           in_pix;

  assign accept = pixel_in.valid && pixel_in.ready;

  always_comb begin
    last_col = WCMP_W'(col_count) >= (width_eff - WCMP_W'(1));
    last_row = HCMP_W'(row_count) >= (height_eff - HCMP_W'(1));
    if (last_col) begin
      col_count_next = '0;
      row_count_next = last_row ? '0 : row_count + ROW_W'(1);
    end else begin
      col_count_next = col_count + COL_W'(1);
      row_count_next = row_count;
    end
    in_meta.col      = COORD_W'(col_count);
    in_meta.row      = COORD_W'(row_count);
    in_meta.emit     = (row_count != '0);
    in_meta.compute  = (row_count >= ROW_W'(2)) && (col_count != '0) && !last_col;
    in_meta.last_row = last_row;
    in_meta.last_col = last_col;
    in_pix           = '{a: pixel_in.chan_a, b: pixel_in.chan_b, c: pixel_in.chan_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_adv, s2_adv, s3_adv;
  logic s1_free, s2_free, s3_free, s4_free;
  logic s4_second;
  logic s4_final;
  logic out_fire;
  item_meta_t s1_meta, s2_meta, s3_meta, s4_meta;

  // Ready ripples back from the output register; an item with no result drops at stage 3
  assign out_fire = result_out.valid && result_out.ready;
  assign s4_final = !s4_meta.last_row || s4_second;
  assign s4_free  = !s4_valid || (out_fire && s4_final);
  assign s3_adv   = s3_valid && (s4_free || !s3_meta.emit);
  assign s3_free  = !s3_valid || s3_adv;
  assign s2_adv   = s2_valid && s3_free;
  assign s2_free  = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_adv;

  assign pixel_in.ready = s1_free;

  // ---------------------------------------------------------------- stage 1: line stores
  logic [COL_W-1:0] s1_x;
  pixel_t           s1_pix;
  pixel_t           s1_ctr;
  pixel_t           s1_lft;
  pixel_t           rgt_q;
  pixel_t           up_q;

  // The newer store is read one column ahead: that read is the right neighbor of
  // this item and the center of the next one. Write back once the item moves on.
  tgd_line_store #(.DEPTH(MAX_WIDTH)) u_newer_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_x),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (col_count_next),
    .rdata (rgt_q)
  );

  tgd_line_store #(.DEPTH(MAX_WIDTH)) u_older_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_x),
    .wdata (s1_ctr),
    .re    (accept),
    .raddr (col_count),
    .rdata (up_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Shift the window: previous center becomes the left neighbor
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= in_meta;
      s1_x    <= col_count;
      s1_pix  <= in_pix;
      s1_ctr  <= rgt_q;
      s1_lft  <= s1_ctr;
    end
  end

  // ---------------------------------------------------------------- stage 2: neighbor lanes
  pixel_t              nbr [NUM_DIRS];
  sum_t [NUM_DIRS-1:0] lane_sum;
  sum_t [NUM_DIRS-1:0] s2_sums;

  always_comb begin
    nbr[DIR_LEFT]  = s1_lft;
    nbr[DIR_RIGHT] = rgt_q;
    nbr[DIR_UP]    = up_q;
    nbr[DIR_DOWN]  = s1_pix;
  end

  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_lane
    tgd_diff_lane u_lane (
      .center   (s1_ctr),
      .neighbor (nbr[g]),
      .nch      (nch_eff),
      .sum      (lane_sum[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_meta <= s1_meta;
      s2_sums <= lane_sum;
    end
  end

  // ---------------------------------------------------------------- stage 3: merge
  sum_t merged;
  sum_t s3_max;

  tgd_merge u_merge (
    .sums    (s2_sums),
    .max_sum (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_adv) begin
      s3_valid <= 1'b1;
    end else if (s3_adv) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_meta <= s2_meta;
      s3_max  <= merged;
    end
  end

  // ---------------------------------------------------------------- stage 4: output register
  logic [VAL_W-1:0] s4_value;

  // Last-row items hold for a second beat that reports the pixel itself
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      s4_second <= 1'b0;
    end else if (s3_adv && s3_meta.emit) begin
      s4_valid  <= 1'b1;
      s4_second <= 1'b0;
    end else if (out_fire) begin
      if (s4_final) begin
        s4_valid <= 1'b0;
      end else begin
        s4_second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s3_meta.emit) begin
      s4_meta  <= s3_meta;
      s4_value <= s3_meta.compute ? scale_value(s3_max, nch_eff) : '0;
    end
  end

  assign result_out.valid         = s4_valid;
  assign result_out.texture_value = s4_second ? '0 : s4_value;
  assign result_out.out_column    = s4_meta.col;
  assign result_out.out_row       = s4_second ? s4_meta.row : s4_meta.row - COORD_W'(1);
  assign result_out.run_last      = s4_final;
  assign result_out.frame_done    = s4_second && s4_meta.last_col;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for texture_gradient_descriptor.
// Needs tgd_pkg, the tgd_pixel_if / tgd_result_if interfaces and the block's RTL.
module tb_top;
  import tgd_pkg::*;

  localparam int unsigned STORE_DEPTH = 2048;  // MAX_WIDTH of the instance
  localparam int unsigned ROWS_MAX    = 2048;  // MAX_HEIGHT of the instance
  localparam int unsigned SETTLE_CYC  = 10;
  localparam int unsigned HOLD_LEN    = 400;   // long output back-pressure stretch
  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no item moving
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned REPORT_CAP  = 40;

  typedef enum int unsigned {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;
  typedef enum int unsigned {TONE_RANDOM, TONE_EXTREME, TONE_SMOOTH} tone_t;

  // One result item as the block emits it
  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               done;
  } texel_t;

  logic             clk;
  logic             rst;
  logic             cfg_en;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tgd_pixel_if  pix ();
  tgd_result_if res ();

  texture_gradient_descriptor u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pix),
    .result_out (res)
  );

  // Shadow registers and predictor state; written only while the block is idle
  // (registers) or from the pixel driver (stores and position).
  logic [CFG_W-1:0] width_reg  = RESET_FRAME_WIDTH;
  logic [CFG_W-1:0] height_reg = RESET_FRAME_HEIGHT;
  nch_t             chan_reg   = RESET_CHANNEL_COUNT;
  pixel_t           row_back2 [STORE_DEPTH];   // two rows above the incoming pixel
  pixel_t           row_back1 [STORE_DEPTH];   // row directly above
  int unsigned      pos_col = 0;
  int unsigned      pos_row = 0;

  pixel_t      pixel_backlog [$];   // items waiting for the driver
  texel_t      texture_due [$];     // predicted results, oldest first

  gap_mode_t   gap_mode     = GAP_NONE;
  tone_t       frame_tone   = TONE_RANDOM;
  logic [7:0]  tone_level   = 8'd0;
  logic        hold_request = 1'b0;
  logic        hold_used;
  int unsigned hold_cycles;

  int unsigned mismatches  = 0;
  int unsigned items_in    = 0;
  int unsigned results_out = 0;
  int unsigned frames_sent = 0;
  int unsigned reg_writes  = 0;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Reference behavior
  // ---------------------------------------------------------------------------

  // Width and height outside 3..MAX act as the nearest end of the range
  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (32'(v) < MIN_DIM) return MIN_DIM;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // Sum of absolute byte differences over the active channels
  function automatic int unsigned diff_total(logic [23:0] p, logic [23:0] q,
                                             int unsigned nch);
    int unsigned s;
    int unsigned ca;
    int unsigned cb;
    s = 0;
    for (int k = 0; k < nch; k++) begin
      ca = 32'(p[8*k +: 8]);
      cb = 32'(q[8*k +: 8]);
      s += (ca > cb) ? ca - cb : cb - ca;
    end
    return s;
  endfunction

  // Advance the predictor by one accepted pixel and queue the results it causes.
  task automatic predict_texture(pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned nch;
    int unsigned x;
    int unsigned y;
    int unsigned peak;
    int unsigned d;
    pixel_t      mid;
    bit          end_col;
    bit          end_row;
    texel_t      t;
    w   = eff_dim(width_reg, STORE_DEPTH);
    h   = eff_dim(height_reg, ROWS_MAX);
    nch = (chan_reg == 2'd0) ? 1 : 32'(chan_reg);
    x   = pos_col;
    y   = pos_row;
    end_col = (x >= w - 1);
    end_row = (y >= h - 1);

    if (y >= 1) begin
      peak = 0;
      // Interior pixel of the row above: left has already moved to the older
      // store, right and center are still in the newer one, below is this item.
      if (y >= 2 && x >= 1 && !end_col) begin
        mid  = row_back1[x];
        peak = diff_total(mid, row_back2[x-1], nch);
        d = diff_total(mid, row_back1[x+1], nch);
        if (d > peak) peak = d;
        d = diff_total(mid, row_back2[x], nch);
        if (d > peak) peak = d;
        d = diff_total(mid, px, nch);
        if (d > peak) peak = d;
        peak = peak / nch;
        if (peak > 255) peak = 255;
      end
      t.value = VAL_W'(peak);
      t.col   = COORD_W'(x);
      t.row   = COORD_W'(y - 1);
      t.last  = !end_row;
      t.done  = 1'b0;
      texture_due.push_back(t);
      // The last row also releases its own border result
      if (end_row) begin
        t.value = '0;
        t.row   = COORD_W'(y);
        t.last  = 1'b1;
        t.done  = end_col;
        texture_due.push_back(t);
      end
    end

    row_back2[x] = row_back1[x];
    row_back1[x] = px;
    if (end_col) begin
      pos_col = 0;
      pos_row = end_row ? 0 : y + 1;
    end else begin
      pos_col = x + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pacing and reporting
  // ---------------------------------------------------------------------------

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_pause();
    case (gap_mode)
      GAP_SEND: return roll(61);
      GAP_BOTH: return roll(25);
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_pause();
    case (gap_mode)
      GAP_RECV: return roll(61);
      GAP_BOTH: return roll(25);
      default:  return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < REPORT_CAP)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: hold an offered item until it is taken, then advance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_pixels
    pixel_t taken;
    pixel_t next_px;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        taken.a = pix.chan_a;
        taken.b = pix.chan_b;
        taken.c = pix.chan_c;
        predict_texture(taken);
        items_in++;
      end
      if (!pix.valid || pix.ready) begin
        if (pixel_backlog.size() != 0 && !sender_pause()) begin
          next_px = pixel_backlog.pop_front();
          pix.valid  <= 1'b1;
          pix.chan_a <= next_px.a;
          pix.chan_b <= next_px.b;
          pix.chan_c <= next_px.c;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure stretch: counted here, armed once by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_used   <= 1'b0;
    end else if (hold_request && !hold_used) begin
      hold_cycles <= HOLD_LEN;
      hold_used   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every taken item with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    texel_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        results_out++;
        if (texture_due.size() == 0) begin
          report_mismatch("result with nothing pending (column)", 32'(res.out_column), 0);
        end else begin
          want = texture_due.pop_front();
          if (res.texture_value !== want.value)
            report_mismatch($sformatf("texture_value at (%0d,%0d)", want.col, want.row),
                            32'(res.texture_value), 32'(want.value));
          if (res.out_column !== want.col)
            report_mismatch("out_column", 32'(res.out_column), 32'(want.col));
          if (res.out_row !== want.row)
            report_mismatch("out_row", 32'(res.out_row), 32'(want.row));
          if (res.run_last !== want.last)
            report_mismatch($sformatf("run_last at (%0d,%0d)", want.col, want.row),
                            32'(res.run_last), 32'(want.last));
          if (res.frame_done !== want.done)
            report_mismatch($sformatf("frame_done at (%0d,%0d)", want.col, want.row),
                            32'(res.frame_done), 32'(want.done));
        end
      end
      res.ready <= (hold_cycles == 0) && !receiver_pause();
    end
  end

  // Watchdog: give up when neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles, %0d results pending",
               idle_cycles, texture_due.size());
      $display("FAIL texture_gradient_descriptor");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register; the block is idle whenever this is called
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH:   width_reg  = val;
      REG_FRAME_HEIGHT:  height_reg = val;
      REG_CHANNEL_COUNT: chan_reg   = val[1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Wait for every queued item to be taken and every result to arrive, then
  // let the pipeline run dry (row-0 items leave nothing to wait for).
  task automatic settle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || pix.valid || texture_due.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pixel_t p;
    p.a = a;
    p.b = b;
    p.c = c;
    pixel_backlog.push_back(p);
  endtask

  function automatic logic [7:0] tone_byte();
    case (frame_tone)
      TONE_EXTREME: return roll(50) ? 8'hFF : 8'h00;
      TONE_SMOOTH:  return tone_level + 8'($urandom_range(7));
      default:      return 8'($urandom_range(255));
    endcase
  endfunction

  // Items left until the predicted position wraps back to the frame start
  function automatic int unsigned items_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned n;
    w = eff_dim(width_reg, STORE_DEPTH);
    h = eff_dim(height_reg, ROWS_MAX);
    x = pos_col;
    y = pos_row;
    n = 0;
    do begin
      n++;
      if (x >= w - 1) begin
        x = 0;
        y = (y >= h - 1) ? 0 : y + 1;
      end else begin
        x++;
      end
    end while (x != 0 || y != 0);
    return n;
  endfunction

  // Queue n pixels of one texture style; returns once they are queued
  task automatic queue_pixels(int unsigned n);
    @(negedge clk);
    frame_tone = tone_t'($urandom_range(2));
    tone_level = 8'($urandom_range(248));
    repeat (n) push_pixel(tone_byte(), tone_byte(), tone_byte());
  endtask

  task automatic run_frame();
    @(negedge clk);
    queue_pixels(items_to_frame_end());
    frames_sent++;
    settle();
  endtask

  // Mostly small frames; now and then a width or height below the minimum
  // or a wider row.
  task automatic random_setting();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    if (roll(10))
      w = CFG_W'($urandom_range(2));
    else if (roll(6))
      w = CFG_W'($urandom_range(30, 80));
    else
      w = CFG_W'($urandom_range(3, 12));
    h = roll(10) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 7));
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, CFG_W'($urandom_range(3)));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  ramp [16];
    int unsigned phase_start;
    rst        = 1'b1;
    cfg_en     = 1'b0;
    cfg_index  = REG_FRAME_WIDTH;
    cfg_data   = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      row_back2[i] = '0;
      row_back1[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame from under-range sizes, three channels: a full-scale
    // center against black neighbors, corners with alternating bit patterns.
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    write_reg(REG_CHANNEL_COUNT, 12'd3);
    @(negedge clk);
    push_pixel(8'hAA, 8'h55, 8'hAA); push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'h55, 8'hAA, 8'h55);
    push_pixel(8'h00, 8'h00, 8'h00); push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'h55, 8'hAA, 8'h55); push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hAA, 8'h55, 8'hAA);
    frames_sent++;
    settle();

    // 4x4 with channel count zero (acts as one): the unused channels carry
    // noise that must be ignored; the peak moves between directions.
    write_reg(REG_FRAME_WIDTH, 12'd4);
    write_reg(REG_FRAME_HEIGHT, 12'd4);
    write_reg(REG_CHANNEL_COUNT, 12'd0);
    ramp = '{8'd10, 8'd200, 8'd30, 8'd40, 8'd250, 8'd100, 8'd90, 8'd0,
             8'd60, 8'd100, 8'd255, 8'd70, 8'd80, 8'd1, 8'd120, 8'd90};
    @(negedge clk);
    foreach (ramp[i]) push_pixel(ramp[i], ~ramp[i], ramp[i] ^ 8'h5A);
    frames_sent++;
    settle();

    for (int ph = GAP_NONE; ph <= GAP_BOTH; ph++) begin
      gap_mode    = gap_mode_t'(ph);
      phase_start = items_in;

      if (gap_mode == GAP_NONE) begin
        // Hold off the output for a long stretch while a wide frame streams
        // in, so the pipeline fills and the input stalls.
        write_reg(REG_FRAME_WIDTH, 12'd100);
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        write_reg(REG_CHANNEL_COUNT, CFG_W'($urandom_range(1, 3)));
        @(negedge clk);
        hold_request = 1'b1;
        run_frame();
      end

      if (gap_mode == GAP_RECV) begin
        // Shrink the frame partway through: the next column already lies past
        // the new last column, so it closes the row; the new height makes the
        // following row the last.
        write_reg(REG_FRAME_WIDTH, 12'd9);
        write_reg(REG_FRAME_HEIGHT, 12'd6);
        write_reg(REG_CHANNEL_COUNT, 12'd2);
        queue_pixels(21);
        settle();
        write_reg(REG_FRAME_WIDTH, 12'd3);
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        run_frame();
      end

      while (items_in - phase_start < PHASE_ITEMS) begin
        random_setting();
        run_frame();
      end
    end

    // Sizes from the top of the register range act as the largest frame; a long
    // first row and a run of rows, each then cut short by a smaller setting.
    gap_mode = GAP_NONE;
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    write_reg(REG_CHANNEL_COUNT, 12'd3);
    queue_pixels(40);
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd5);
    run_frame();
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    write_reg(REG_CHANNEL_COUNT, 12'd2);
    queue_pixels(15);
    settle();
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    run_frame();

    $display("run covered %0d pixel items in %0d frames with %0d register writes",
             items_in, frames_sent, reg_writes);
    $display("%0d result items checked, %0d mismatches", results_out, mismatches);
    if (mismatches == 0) begin
      $display("PASS texture_gradient_descriptor");
    end else begin
      $display("FAIL texture_gradient_descriptor");
    end
    $finish;
  end

endmodule
